@@ rtl/npr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nibble pixel row packer package
// Shared widths, register indexes and the types that pass between the
// top level and the packing core.
// ----------------------------------------------------------------------------
package npr_pkg;

    localparam int PIXEL_W         = 4;
    localparam int PIXELS_PER_WORD = 4;
    localparam int WORD_W          = PIXEL_W * PIXELS_PER_WORD;
    localparam int SLOT_W          = $clog2(PIXELS_PER_WORD);
    localparam int COORD_W         = 16;
    localparam int CFG_IDX_W       = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_RECT_X      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RECT_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RECT_HEIGHT = 2'd2;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(PIXELS_PER_WORD - 1);

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] width;
        logic [COORD_W-1:0] height;
    } t_cfg;

    typedef struct packed {
        logic [WORD_W-1:0] packed_word;
        logic              row_end;
        logic              image_end;
    } t_result;

endpackage

@@ rtl/npr_pack.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nibble pixel row packer core
// Holds the word accumulator, nibble slot and row and column counts, and
// folds one pixel per step into the current word.
// ----------------------------------------------------------------------------
module npr_pack (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  npr_pkg::t_cfg                 i_cfg,
    input  logic                          i_restart,
    input  logic [npr_pkg::SLOT_W-1:0]    i_start_slot,
    input  logic                          i_step,
    input  logic [npr_pkg::PIXEL_W-1:0]   i_pixel,
    output logic                          o_emit,
    output npr_pkg::t_result              o_result
);

    logic [npr_pkg::WORD_W-1:0]  r_acc;
    logic [npr_pkg::WORD_W-1:0]  n_acc;
    logic [npr_pkg::SLOT_W-1:0]  r_slot;
    logic [npr_pkg::SLOT_W-1:0]  n_slot;
    logic [npr_pkg::COORD_W-1:0] r_col;
    logic [npr_pkg::COORD_W-1:0] n_col;
    logic [npr_pkg::COORD_W-1:0] r_row;
    logic [npr_pkg::COORD_W-1:0] n_row;

    logic [npr_pkg::COORD_W-1:0] w_eff;
    logic [npr_pkg::COORD_W-1:0] h_eff;
    logic [npr_pkg::COORD_W-1:0] col_inc;
    logic [npr_pkg::COORD_W:0]   row_inc;
    logic [npr_pkg::WORD_W-1:0]  acc_fill;
    logic                        last_in_row;
    logic                        last_row;
    logic                        full;

    assign w_eff   = (i_cfg.width == '0) ? npr_pkg::COORD_W'(1) : i_cfg.width;
    assign h_eff   = (i_cfg.height == '0) ? npr_pkg::COORD_W'(1) : i_cfg.height;
    assign col_inc = r_col + npr_pkg::COORD_W'(1);
    assign row_inc = {1'b0, r_row} + (npr_pkg::COORD_W + 1)'(1);

    always_comb begin
        for (int i = 0; i < npr_pkg::PIXELS_PER_WORD; i++) begin
            acc_fill[i*npr_pkg::PIXEL_W +: npr_pkg::PIXEL_W] =
                r_acc[i*npr_pkg::PIXEL_W +: npr_pkg::PIXEL_W] |
                ((r_slot == npr_pkg::SLOT_W'(i)) ? i_pixel : '0);
        end
    end

    assign last_in_row = col_inc >= w_eff;
    assign full        = r_slot == npr_pkg::LAST_SLOT;
    assign last_row    = last_in_row && (row_inc >= {1'b0, h_eff});
    assign o_emit      = full || last_in_row;

    assign o_result.packed_word = acc_fill;
    assign o_result.row_end     = last_in_row;
    assign o_result.image_end   = last_row;

    always_comb begin
        n_acc  = r_acc;
        n_slot = r_slot;
        n_col  = r_col;
        n_row  = r_row;
        if (i_restart) begin
            n_acc  = '0;
            n_slot = i_start_slot;
            n_col  = '0;
            n_row  = '0;
        end else if (i_step) begin
            if (!o_emit) begin
                n_acc  = acc_fill;
                n_slot = r_slot + npr_pkg::SLOT_W'(1);
                n_col  = col_inc;
            end else if (last_in_row) begin
                n_acc  = '0;
                n_slot = i_cfg.x[npr_pkg::SLOT_W-1:0];
                n_col  = '0;
                n_row  = last_row ? '0 : row_inc[npr_pkg::COORD_W-1:0];
            end else begin
                n_acc  = '0;
                n_slot = '0;
                n_col  = col_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_slot <= '0;
            r_col  <= '0;
            r_row  <= '0;
        end else begin
            r_acc  <= n_acc;
            r_slot <= n_slot;
            r_col  <= n_col;
            r_row  <= n_row;
        end
    end

`ifndef SYNTHESIS
    a_slot_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && !o_emit && !i_restart |=> r_slot == $past(r_slot) + npr_pkg::SLOT_W'(1))
        else $error("nibble slot did not advance after a non-emitting pixel");

    a_row_end_clears_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_emit && last_in_row |=> r_col == '0)
        else $error("column count not cleared at end of row");
`endif

endmodule

@@ rtl/nibble_pixel_row_packer_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nibble pixel row packer
// Packs 4-bit pixels of a rectangle, four to a 16-bit word, into
// word-aligned rows.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock while the downstream side takes each word.
// A pixel is registered, folded into the accumulator, and a finished word lands
// in the output register, so the sustained rate is one pixel per clock while the
// downstream side takes each word. Pixels that complete no word keep flowing
// while a word waits. Each row starts at nibble rect_x mod 4 with lower nibbles
// zero, and its last word leaves as soon as the last pixel arrives. Any register
// write restarts the rectangle and must only be issued while the block is idle.
// ----------------------------------------------------------------------------
module nibble_pixel_row_packer_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [npr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [npr_pkg::COORD_W-1:0]      i_cfg_wdata,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [npr_pkg::PIXEL_W-1:0]      i_pixel,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [npr_pkg::WORD_W-1:0]       o_packed_word,
    output logic                             o_row_end,
    output logic                             o_image_end
);

    npr_pkg::t_cfg                 r_cfg;
    npr_pkg::t_cfg                 n_cfg;
    logic                          r_s1_valid;
    logic                          n_s1_valid;
    logic [npr_pkg::PIXEL_W-1:0]   r_s1_pixel;
    logic                          r_out_valid;
    logic                          n_out_valid;
    npr_pkg::t_result              r_out;

    logic                          restart;
    logic [npr_pkg::SLOT_W-1:0]    start_slot;
    logic                          emit;
    logic                          advance;
    logic                          accept_in;
    npr_pkg::t_result              result;

    always_comb begin
        n_cfg   = r_cfg;
        restart = 1'b0;
        if (i_cfg_we) begin
            case (i_cfg_index)
                npr_pkg::CFG_RECT_X: begin
                    n_cfg.x = i_cfg_wdata;
                    restart = 1'b1;
                end
                npr_pkg::CFG_RECT_WIDTH: begin
                    n_cfg.width = i_cfg_wdata;
                    restart     = 1'b1;
                end
                npr_pkg::CFG_RECT_HEIGHT: begin
                    n_cfg.height = i_cfg_wdata;
                    restart      = 1'b1;
                end
                default: begin
                    restart = 1'b0;
                end
            endcase
        end
    end

    assign start_slot = n_cfg.x[npr_pkg::SLOT_W-1:0];

    npr_pack u_pack (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_restart    (restart),
        .i_start_slot (start_slot),
        .i_step       (advance),
        .i_pixel      (r_s1_pixel),
        .o_emit       (emit),
        .o_result     (result)
    );

    assign advance    = r_s1_valid && (!emit || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !advance;
    assign accept_in  = i_in_valid && !o_in_stall;

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (accept_in) begin
            n_s1_valid = 1'b1;
        end else if (advance) begin
            n_s1_valid = 1'b0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (advance && emit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.x      <= '0;
            r_cfg.width  <= npr_pkg::COORD_W'(1);
            r_cfg.height <= npr_pkg::COORD_W'(1);
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_cfg       <= n_cfg;
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_s1_pixel <= i_pixel;
        end
        if (advance && emit) begin
            r_out <= result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_packed_word = r_out.packed_word;
    assign o_row_end     = r_out.row_end;
    assign o_image_end   = r_out.image_end;

`ifndef SYNTHESIS
    a_image_end_has_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_image_end |-> o_row_end)
        else $error("image end flagged on a word that does not end a row");

    a_emit_reaches_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && emit |=> o_out_valid)
        else $error("completed word did not reach the output register");

    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !advance |=> r_s1_valid && $stable(r_s1_pixel))
        else $error("held pixel was lost or changed");
`endif

endmodule
